// ===== design/fpbe_pkg.sv =====
// Shared constants, codes and types of the frame buffer pixel blend engine.
// No dependencies; fpbe_store, fpbe_mix, the core and the checker use this package.
package fpbe_pkg;

  // Frame store geometry
  localparam int unsigned STORE_BYTES = 2097152;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam int unsigned ROW_DEPTH   = STORE_BYTES / 8;
  localparam int unsigned ROW_W       = $clog2(ROW_DEPTH);

  // Field widths
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned PITCH_W = 15;
  localparam int unsigned PROD_W  = COORD_W + PITCH_W;
  localparam int unsigned FULL_W  = PROD_W + 1;

  // Highest legal start address for a 3 or 4 byte pixel
  localparam logic [FULL_W-1:0] LIMIT_24 = FULL_W'(STORE_BYTES - 3);
  localparam logic [FULL_W-1:0] LIMIT_32 = FULL_W'(STORE_BYTES - 4);

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_BLEND = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OOB  = 2'd1;
  localparam logic [1:0] STAT_MODE = 2'd2;

  // Depth modes
  localparam logic [1:0] DEPTH_24 = 2'd0;
  localparam logic [1:0] DEPTH_32 = 2'd1;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PITCH  = 2'd2;
  localparam logic [1:0] CFG_DEPTH  = 2'd3;

  // Configuration reset values
  localparam logic [DIM_W-1:0]   RST_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0]   RST_HEIGHT = DIM_W'(480);
  localparam logic [PITCH_W-1:0] RST_PITCH  = PITCH_W'(2560);
  localparam logic [1:0]         RST_DEPTH  = DEPTH_32;

  // Request from the control path to the frame store
  typedef struct packed {
    logic               rd;
    logic               wr;
    logic               four;   // 32 bpp: fourth byte written as zero
    logic [ADDR_W-1:0]  addr;   // byte address of the pixel
    logic [COLOR_W-1:0] color;  // 0xRRGGBB
  } store_req_t;

endpackage

// ===== design/fpbe_bank_ram.sv =====
// Generic single-port RAM of 32-bit words with byte enables and a registered read.
// No dependencies.
module fpbe_bank_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic          wr_en_i,
  input  logic [3:0]    be_i,
  input  logic [AW-1:0] addr_i,
  input  logic [31:0]   wdata_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  // Byte-enabled write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int b = 0; b < 4; b++) begin
        if (be_i[b]) begin
          mem[addr_i][8*b +: 8] <= wdata_i[8*b +: 8];
        end
      end
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fpbe_store.sv =====
// Byte-addressed frame store: two word banks (even and odd words), lane mapping
// of unaligned pixels, and the clearing pass after reset. Uses fpbe_pkg, fpbe_bank_ram.
module fpbe_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fpbe_pkg::store_req_t          req_i,
  output logic                          busy_o,
  output logic [fpbe_pkg::COLOR_W-1:0]  rd_color_o
);
  import fpbe_pkg::*;

  localparam int unsigned WA_W = ADDR_W - 2;

  logic [WA_W-1:0]  wa;
  logic [WA_W:0]    wa_inc;
  logic [1:0]       off;
  logic [63:0]      wdata64;
  logic [7:0]       mask8;
  logic [ROW_W-1:0] even_row, odd_row;
  logic [3:0]       even_be, odd_be;
  logic [31:0]      even_wd, odd_wd;
  logic             bank_wr;
  logic [31:0]      even_rd, odd_rd;
  logic [31:0]      lo_word, hi_word;
  logic [63:0]      window;

  logic             clr_busy_q, clr_busy_d;
  logic [ROW_W-1:0] clr_row_q, clr_row_d;
  logic             wa0_q;
  logic [1:0]       off_q;

  // Pixel spans word wa and possibly wa+1; the two always sit in different banks
  assign wa     = req_i.addr[ADDR_W-1:2];
  assign off    = req_i.addr[1:0];
  assign wa_inc = {1'b0, wa} + (WA_W+1)'(1);

  assign wdata64 = 64'(req_i.color) << {off, 3'b000};
  assign mask8   = (req_i.four ? 8'h0F : 8'h07) << off;

  // Bank steering, or the clearing sweep
  always_comb begin
    if (clr_busy_q) begin
      even_row = clr_row_q;
      odd_row  = clr_row_q;
      even_be  = 4'hF;
      odd_be   = 4'hF;
      even_wd  = '0;
      odd_wd   = '0;
      bank_wr  = 1'b1;
    end else begin
      even_row = wa_inc[WA_W-1:1];
      odd_row  = wa[WA_W-1:1];
      bank_wr  = req_i.wr;
      if (wa[0]) begin
        odd_be  = mask8[3:0];
        odd_wd  = wdata64[31:0];
        even_be = mask8[7:4];
        even_wd = wdata64[63:32];
      end else begin
        even_be = mask8[3:0];
        even_wd = wdata64[31:0];
        odd_be  = mask8[7:4];
        odd_wd  = wdata64[63:32];
      end
    end
  end

  fpbe_bank_ram #(.DEPTH(ROW_DEPTH)) u_even (
    .clk_i   (clk_i),
    .rd_en_i (req_i.rd & ~clr_busy_q),
    .wr_en_i (bank_wr),
    .be_i    (even_be),
    .addr_i  (even_row),
    .wdata_i (even_wd),
    .rdata_o (even_rd)
  );

  fpbe_bank_ram #(.DEPTH(ROW_DEPTH)) u_odd (
    .clk_i   (clk_i),
    .rd_en_i (req_i.rd & ~clr_busy_q),
    .wr_en_i (bank_wr),
    .be_i    (odd_be),
    .addr_i  (odd_row),
    .wdata_i (odd_wd),
    .rdata_o (odd_rd)
  );

  // Clearing pass: one row of both banks per cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_row_d  = clr_row_q;
    if (clr_busy_q) begin
      clr_row_d = clr_row_q + ROW_W'(1);
      if (clr_row_q == ROW_W'(ROW_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_row_q  <= clr_row_d;
    end
  end

  // Lane position of the pending read
  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      wa0_q <= wa[0];
      off_q <= off;
    end
  end

  // Reassemble the pixel from the two words
  assign lo_word    = wa0_q ? odd_rd : even_rd;
  assign hi_word    = wa0_q ? even_rd : odd_rd;
  assign window     = {hi_word, lo_word} >> {off_q, 3'b000};
  assign rd_color_o = window[COLOR_W-1:0];
  assign busy_o     = clr_busy_q;

endmodule

// ===== design/fpbe_mix.sv =====
// Per-channel alpha blend: floor((src*a + dst*(255-a)) / 255).
// Uses fpbe_pkg.
module fpbe_mix (
  input  logic [fpbe_pkg::COLOR_W-1:0] src_i,
  input  logic [fpbe_pkg::COLOR_W-1:0] dst_i,
  input  logic [7:0]                   alpha_i,
  output logic [fpbe_pkg::COLOR_W-1:0] mix_o
);
  import fpbe_pkg::*;

  logic [7:0]  inv_alpha;
  logic [15:0] num  [3];
  logic [16:0] corr [3];

  assign inv_alpha = 8'hFF - alpha_i;

  // Divide by 255 as (n + (n >> 8) + 1) >> 8, exact for n below 65535
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c]  = 16'(src_i[8*c +: 8]) * 16'(alpha_i) +
                16'(dst_i[8*c +: 8]) * 16'(inv_alpha);
      corr[c] = {1'b0, num[c]} + 17'(num[c][15:8]) + 17'd1;
      mix_o[8*c +: 8] = corr[c][15:8];
    end
  end

endmodule

// ===== design/framebuffer_pixel_blend_engine_core.sv =====
// Frame buffer pixel engine: write, read or alpha-blend one pixel per transaction.
// One transaction at a time; after acceptance a write or a flagged item passes ADDR and
// DONE, a read ADDR, RESP and DONE, a blend ADDR, RESP, MIX and DONE (read, mix, write back
// through the store port); DONE loads the output register once it is free.
// Reset: registers return to 640x480, pitch 2560, 32 bpp; the store is then cleared
// one row of 8 bytes per cycle, all 262144 rows, with input ready held low.
module framebuffer_pixel_blend_engine_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [fpbe_pkg::PITCH_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     op_i,
  input  logic [fpbe_pkg::COORD_W-1:0]   x_coord_i,
  input  logic [fpbe_pkg::COORD_W-1:0]   y_coord_i,
  input  logic [fpbe_pkg::COLOR_W-1:0]   pixel_color_i,
  input  logic [7:0]                     alpha_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fpbe_pkg::COLOR_W-1:0]   read_color_o,
  output logic [1:0]                     status_o
);
  import fpbe_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_RESP = 3'd2;
  localparam logic [2:0] ST_MIX  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]         state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;
  logic               accept;

  logic [DIM_W-1:0]   width_q, height_q;
  logic [PITCH_W-1:0] pitch_q;
  logic [1:0]         depth_q;

  logic [1:0]         op_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [COLOR_W-1:0] color_q, blend_q;
  logic [7:0]         alpha_q;
  logic [PROD_W-1:0]  prod_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [COLOR_W-1:0] res_color_q, read_color_q;
  logic [1:0]         res_status_q, status_q;

  logic               nb4, mode_bad, oob;
  logic [15:0]        min_pitch;
  logic [13:0]        x_off;
  logic [FULL_W-1:0]  addr_full, addr_limit;
  logic [1:0]         item_status;

  store_req_t         store_req;
  logic               store_busy;
  logic [COLOR_W-1:0] store_rd;
  logic [COLOR_W-1:0] mix_color;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      pitch_q  <= RST_PITCH;
      depth_q  <= RST_DEPTH;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        CFG_PITCH:  pitch_q  <= cfg_data_i;
        CFG_DEPTH:  depth_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Mode check
  assign nb4       = (depth_q == DEPTH_32);
  assign min_pitch = nb4 ? {1'b0, width_q, 2'b00}
                         : {3'b000, width_q} + {2'b00, width_q, 1'b0};
  assign mode_bad  = (width_q == '0) || (height_q == '0) || depth_q[1] ||
                     ({1'b0, pitch_q} < min_pitch);

  // Address and bounds
  assign x_off      = nb4 ? {x_q, 2'b00} : {2'b00, x_q} + {1'b0, x_q, 1'b0};
  assign addr_full  = {1'b0, prod_q} + FULL_W'(x_off);
  assign addr_limit = nb4 ? LIMIT_32 : LIMIT_24;
  assign oob        = ({1'b0, x_q} >= width_q) || ({1'b0, y_q} >= height_q) ||
                      (addr_full > addr_limit);
  assign item_status = mode_bad ? STAT_MODE : (oob ? STAT_OOB : STAT_OK);

  // Frame store requests
  always_comb begin
    store_req       = '0;
    store_req.four  = nb4;
    store_req.addr  = addr_full[ADDR_W-1:0];
    store_req.color = color_q;
    if (state_q == ST_ADDR && item_status == STAT_OK) begin
      store_req.wr = (op_q == OP_WRITE);
      store_req.rd = (op_q == OP_READ) || (op_q == OP_BLEND);
    end else if (state_q == ST_MIX) begin
      store_req.wr    = 1'b1;
      store_req.addr  = addr_q;
      store_req.color = blend_q;
    end
  end

  fpbe_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (store_req),
    .busy_o     (store_busy),
    .rd_color_o (store_rd)
  );

  fpbe_mix u_mix (
    .src_i   (color_q),
    .dst_i   (store_rd),
    .alpha_i (alpha_q),
    .mix_o   (mix_color)
  );

  // Sequencer
  assign in_ready_o = (state_q == ST_IDLE) && !store_busy;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_ADDR;
      ST_ADDR: begin
        if (item_status == STAT_OK && (op_q == OP_READ || op_q == OP_BLEND)) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RESP: state_d = (op_q == OP_BLEND) ? ST_MIX : ST_DONE;
      ST_MIX:  state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_DONE && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Transaction payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      x_q     <= x_coord_i;
      y_q     <= y_coord_i;
      color_q <= pixel_color_i;
      alpha_q <= alpha_i;
      prod_q  <= PROD_W'(y_coord_i) * PROD_W'(pitch_q);
    end
    if (state_q == ST_ADDR) begin
      addr_q       <= addr_full[ADDR_W-1:0];
      res_status_q <= item_status;
      res_color_q  <= '0;
    end
    if (state_q == ST_RESP) begin
      if (op_q == OP_READ) begin
        res_color_q <= store_rd;
      end
      blend_q <= mix_color;
    end
    if (state_q == ST_DONE && out_free) begin
      read_color_q <= res_color_q;
      status_q     <= res_status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_color_o = read_color_q;
  assign status_o     = status_q;

endmodule

// ===== design/fpbe_checker.sv =====
// Port-level checks of the pixel engine, attached to the top level by bind.
// Uses fpbe_pkg and framebuffer_pixel_blend_engine_core.
module fpbe_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [fpbe_pkg::COLOR_W-1:0] read_color_o,
  input logic [1:0]                   status_o
);
  import fpbe_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_color_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_OK || status_o == STAT_OOB || status_o == STAT_MODE))
    else $error("undefined status code");

  // A flagged item never returns pixel data
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> read_color_o == '0)
    else $error("flagged transaction returned colour data");

  // One transaction in flight: no acceptance in the cycle after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("back-to-back acceptance");

endmodule

bind framebuffer_pixel_blend_engine_core fpbe_checker u_fpbe_checker (.*);
